// ===== rtl/core/pif_pkg.sv =====
`timescale 1ns / 1ps

package pif_pkg;

	localparam int unsigned VarsDefault = 4;
	localparam int unsigned MaxOut      = 32;
	localparam int unsigned EmitW       = $clog2(MaxOut);

	localparam logic ActLoad  = 1'b0;
	localparam logic ActSolve = 1'b1;

	localparam logic [1:0] KindOff = 2'd0;
	localparam logic [1:0] KindOn  = 2'd1;
	localparam logic [1:0] KindDc  = 2'd2;

	// saturating per-point count of covering primes
	localparam logic [1:0] CovNone = 2'd0;
	localparam logic [1:0] CovOne  = 2'd1;
	localparam logic [1:0] CovMany = 2'd2;

	typedef struct packed {
		logic       action;
		logic [3:0] term_index;
		logic [1:0] term_kind;
	} in_item_t;

	typedef struct packed {
		logic [3:0] cube_value;
		logic [3:0] cube_mask;
		logic       essential;
		logic       found;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic solve_start;
		logic cnt_inc;
		logic cov_upd;
		logic pend_load;
		logic emit;
		logic emit_last;
		logic clear_table;
	} pif_cmd_t;

	typedef struct packed {
		logic cube_prime;
		logic cnt_last;
		logic pend_valid;
		logic emit_cap;
		logic out_free;
	} pif_stat_t;

endpackage

// ===== rtl/core/pif_stream_if.sv =====
`timescale 1ns / 1ps

interface pif_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/pif_ctrl.sv =====
`timescale 1ns / 1ps

module pif_ctrl
	import pif_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_action,
	output logic      cmd_ready,
	input  pif_stat_t st,
	output pif_cmd_t  c
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_COUNT = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_FINAL = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		c       = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (cmd_action == ActSolve) begin
						c.solve_start = 1'b1;
						state_d       = S_COUNT;
					end else begin
						c.load = 1'b1;
					end
				end
			end
			S_COUNT: begin
				c.cnt_inc = 1'b1;
				c.cov_upd = st.cube_prime;
				if (st.cnt_last) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.out_free) begin
					c.cnt_inc = 1'b1;
					if (st.cube_prime) begin
						c.pend_load = 1'b1;
						if (st.pend_valid) begin
							c.emit = 1'b1;
							if (st.emit_cap) begin
								c.emit_last   = 1'b1;
								c.clear_table = 1'b1;
								state_d       = S_IDLE;
							end
						end
					end
					if (st.cnt_last && state_d == S_SCAN) begin
						state_d = S_FINAL;
					end
				end
			end
			S_FINAL: begin
				if (st.out_free) begin
					c.emit        = 1'b1;
					c.emit_last   = 1'b1;
					c.clear_table = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/pif_dp.sv =====
`timescale 1ns / 1ps

module pif_dp
	import pif_pkg::*;
#(
	parameter int unsigned VARIABLES = VarsDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pif_cmd_t  c,
	output pif_stat_t st,
	input  logic [3:0] term_index,
	input  logic [1:0] term_kind,
	output logic      out_valid,
	output out_item_t out_data,
	input  logic      out_ready
);

	localparam int unsigned NPoints = 1 << VARIABLES;
	localparam int unsigned CntW    = 2 * VARIABLES;

	logic [NPoints-1:0]   on_q;
	logic [NPoints-1:0]   dc_q;
	logic [NPoints-1:0]   allowed;
	logic [1:0]           cov_q [NPoints];
	logic [CntW-1:0]      cnt_q;
	logic [VARIABLES-1:0] cur_mask;
	logic [VARIABLES-1:0] cur_value;
	logic [NPoints-1:0]   in_cube;
	logic [VARIABLES-1:0] nb_ok;
	logic                 self_ok;
	logic                 cube_prime;
	logic                 cube_ess;
	logic [VARIABLES+3:0] ext_index;
	logic [VARIABLES-1:0] row;

	logic [VARIABLES-1:0] pend_value_q;
	logic [VARIABLES-1:0] pend_mask_q;
	logic                 pend_ess_q;
	logic                 pend_valid_q;
	logic [EmitW-1:0]     emit_cnt_q;
	logic [VARIABLES+3:0] ext_value;
	logic [VARIABLES+3:0] ext_mask;
	logic                 out_valid_q;
	out_item_t            out_q;

	assign allowed   = on_q | dc_q;
	assign cur_mask  = cnt_q[CntW-1:VARIABLES];
	assign cur_value = cnt_q[VARIABLES-1:0];
	assign ext_index = {{VARIABLES{1'b0}}, term_index};
	assign row       = ext_index[VARIABLES-1:0];

	always_comb begin
		logic [NPoints-1:0]   in_nb;
		logic [VARIABLES-1:0] pv;
		logic [VARIABLES-1:0] bitv;
		in_cube  = '0;
		nb_ok    = '0;
		cube_ess = 1'b0;
		for (int p = 0; p < NPoints; p++) begin
			pv         = VARIABLES'(p);
			in_cube[p] = ((pv & ~cur_mask) == cur_value);
			if (on_q[p] && in_cube[p] && cov_q[p] == CovOne) begin
				cube_ess = 1'b1;
			end
		end
		self_ok = ~|(in_cube & ~allowed);
		// a free variable can be dashed when the neighbor cube is allowed too
		for (int b = 0; b < VARIABLES; b++) begin
			bitv  = VARIABLES'(1) << b;
			in_nb = '0;
			for (int p = 0; p < NPoints; p++) begin
				pv       = VARIABLES'(p);
				in_nb[p] = ((pv & ~cur_mask) == (cur_value ^ bitv));
			end
			nb_ok[b] = !cur_mask[b] && ~|(in_nb & ~allowed);
		end
		cube_prime = ((cur_value & cur_mask) == '0) && self_ok && ~|nb_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q <= '0;
			dc_q <= '0;
		end else if (c.clear_table) begin
			on_q <= '0;
			dc_q <= '0;
		end else if (c.load) begin
			case (term_kind)
				KindOff: begin
					on_q[row] <= 1'b0;
					dc_q[row] <= 1'b0;
				end
				KindOn: begin
					on_q[row] <= 1'b1;
					dc_q[row] <= 1'b0;
				end
				KindDc: begin
					on_q[row] <= 1'b0;
					dc_q[row] <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (c.solve_start) begin
			cnt_q <= '0;
		end else if (c.cnt_inc) begin
			cnt_q <= cnt_q + CntW'(1);
		end
		for (int p = 0; p < NPoints; p++) begin
			if (c.solve_start) begin
				cov_q[p] <= CovNone;
			end else if (c.cov_upd && in_cube[p] && cov_q[p] != CovMany) begin
				cov_q[p] <= cov_q[p] + 2'd1;
			end
		end
		if (c.solve_start) begin
			emit_cnt_q <= '0;
		end else if (c.emit) begin
			emit_cnt_q <= emit_cnt_q + EmitW'(1);
		end
		if (c.pend_load) begin
			pend_value_q <= cur_value;
			pend_mask_q  <= cur_mask;
			pend_ess_q   <= cube_ess;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (c.solve_start) begin
			pend_valid_q <= 1'b0;
		end else if (c.pend_load) begin
			pend_valid_q <= 1'b1;
		end
	end

	assign ext_value = {4'b0000, pend_value_q};
	assign ext_mask  = {4'b0000, pend_mask_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (c.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (c.emit) begin
			out_q.cube_value <= pend_valid_q ? ext_value[3:0] : 4'b0000;
			out_q.cube_mask  <= pend_valid_q ? ext_mask[3:0] : 4'b0000;
			out_q.essential  <= pend_valid_q & pend_ess_q;
			out_q.found      <= pend_valid_q;
			out_q.last       <= c.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign st.cube_prime = cube_prime;
	assign st.cnt_last   = &cnt_q;
	assign st.pend_valid = pend_valid_q;
	assign st.emit_cap   = (emit_cnt_q == EmitW'(MaxOut - 1));
	assign st.out_free   = !out_valid_q || out_ready;

endmodule

// ===== rtl/core/prime_implicant_finder.sv =====
`timescale 1ns / 1ps

// Prime implicant finder. Load items (action 0) set one truth-table row to off,
// minterm or don't-care; kind 3 is ignored. A solve item (action 1) makes
// two sweeps over all 4^VARIABLES mask/value codes: the first counts, per point,
// how many primes cover it; the second finds the primes again in ascending
// mask, then value order, tags each essential one and streams it out through
// a pending register and an output register. The command side is not ready
// during a solve, and a stall on the result side holds the solve. At most 32
// primes are returned, the final one flagged last, and the second sweep stops
// early at that limit; an empty function returns one item with found low.
// The table is cleared when a solve ends.

module prime_implicant_finder
	import pif_pkg::*;
#(
	parameter int unsigned VARIABLES = VarsDefault
) (
	input logic          clk,
	input logic          arst_n,
	pif_stream_if.sink   cmd,
	pif_stream_if.source result
);

	pif_cmd_t  c;
	pif_stat_t st;
	in_item_t  in_item;
	out_item_t out_item;
	logic      out_valid;

	assign in_item = cmd.data;

	pif_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd.valid),
		.cmd_action (in_item.action),
		.cmd_ready  (cmd.ready),
		.st         (st),
		.c          (c)
	);

	pif_dp #(
		.VARIABLES (VARIABLES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.c          (c),
		.st         (st),
		.term_index (in_item.term_index),
		.term_kind  (in_item.term_kind),
		.out_valid  (out_valid),
		.out_data   (out_item),
		.out_ready  (result.ready)
	);

	assign result.valid = out_valid;
	assign result.data  = out_item;

endmodule

// ===== rtl/core/pif_checker.sv =====
`timescale 1ns / 1ps

module pif_checker
	import pif_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_ready,
	input out_item_t res_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result item changed while stalled");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.found |-> res_data.last)
		else $error("empty result not flagged last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.found |->
		res_data.cube_value == 4'b0000 && res_data.cube_mask == 4'b0000 &&
		!res_data.essential)
		else $error("empty result carries cube data");

	a_cube_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.found |-> (res_data.cube_value & res_data.cube_mask) == 4'b0000)
		else $error("cube value set under a dash");

endmodule

bind prime_implicant_finder pif_checker u_pif_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import pif_pkg::*;

	localparam int unsigned Vars       = VarsDefault;
	localparam int unsigned NPts       = 1 << Vars;
	localparam int unsigned NumRand    = 150;
	localparam int unsigned QuietMax   = 20000;
	localparam int unsigned DrainCyc   = 2 * NPts * NPts + 64;
	localparam logic [1:0]  KindUnused = 2'd3;

	typedef struct {
		in_item_t    item;
		int unsigned phase;
	} stim_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic     drv_valid = 1'b0;
	in_item_t drv_data  = '0;
	logic     rcv_ready = 1'b0;

	pif_stream_if #(.T(in_item_t))  cmd_if ();
	pif_stream_if #(.T(out_item_t)) res_if ();

	assign cmd_if.valid = drv_valid;
	assign cmd_if.data  = drv_data;
	assign res_if.ready = rcv_ready;

	prime_implicant_finder #(.VARIABLES(Vars)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.result(res_if)
	);

	always #10 clk = ~clk;

	stim_t           stim_q[$];
	out_item_t       primes_due[$];
	logic [NPts-1:0] table_on    = '0;
	logic [NPts-1:0] table_dc    = '0;
	int unsigned     rx_phase    = 0;
	int unsigned     items_taken = 0;
	int unsigned     n_items     = 0;
	int unsigned     errors      = 0;
	int unsigned     quiet       = 0;

	function automatic int unsigned tx_idle(int unsigned ph);
		case (ph)
			0: return 26;
			1: return 56;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned rx_idle(int unsigned ph);
		case (ph)
			0: return 56;
			1: return 26;
			default: return 0;
		endcase
	endfunction

	task automatic flag_error(string msg);
		$display("[%0t] ERROR: %s", $time, msg);
		errors++;
	endtask

	// every point of the cube is a minterm or a don't-care
	function automatic bit cube_allowed(int m, int v);
		for (int p = 0; p < NPts; p++) begin
			if ((p & ~m) == v && !(table_on[p] || table_dc[p]))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit cube_is_prime(int m, int v);
		if (!cube_allowed(m, v))
			return 1'b0;
		for (int b = 0; b < Vars; b++) begin
			if (!m[b] && cube_allowed(m | (1 << b), v & ~(1 << b)))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic solve_table();
		bit        prime_map [NPts][NPts];
		int        cover_cnt [NPts];
		int        n_total;
		int        n_out;
		bit        ess;
		out_item_t res;
		n_total = 0;
		for (int m = 0; m < NPts; m++) begin
			for (int v = 0; v < NPts; v++) begin
				prime_map[m][v] = ((v & m) == 0) && cube_is_prime(m, v);
				if (prime_map[m][v])
					n_total++;
			end
		end
		if (n_total > MaxOut)
			n_total = MaxOut;
		for (int p = 0; p < NPts; p++) begin
			cover_cnt[p] = 0;
			for (int m = 0; m < NPts; m++)
				for (int v = 0; v < NPts; v++)
					if (prime_map[m][v] && (p & ~m) == v)
						cover_cnt[p]++;
		end
		n_out = 0;
		for (int m = 0; m < NPts; m++) begin
			for (int v = 0; v < NPts; v++) begin
				if (prime_map[m][v] && n_out < n_total) begin
					ess = 1'b0;
					for (int p = 0; p < NPts; p++)
						if (table_on[p] && (p & ~m) == v && cover_cnt[p] == 1)
							ess = 1'b1;
					res.cube_value = v[3:0];
					res.cube_mask  = m[3:0];
					res.essential  = ess;
					res.found      = 1'b1;
					res.last       = (n_out == n_total - 1);
					primes_due.push_back(res);
					n_out++;
				end
			end
		end
		if (n_total == 0) begin
			res = '0;
			res.last = 1'b1;
			primes_due.push_back(res);
		end
		table_on = '0;
		table_dc = '0;
	endtask

	task automatic apply_cmd(in_item_t it);
		int unsigned row;
		row = it.term_index & (NPts - 1);
		if (it.action == ActSolve) begin
			solve_table();
		end else begin
			case (it.term_kind)
				KindOff: begin
					table_on[row] = 1'b0;
					table_dc[row] = 1'b0;
				end
				KindOn: begin
					table_on[row] = 1'b1;
					table_dc[row] = 1'b0;
				end
				KindDc: begin
					table_on[row] = 1'b0;
					table_dc[row] = 1'b1;
				end
				default: ;
			endcase
		end
	endtask

	task automatic check_prime(out_item_t got);
		out_item_t want;
		if (primes_due.size() == 0) begin
			flag_error($sformatf("result %h with nothing expected", got));
			return;
		end
		want = primes_due.pop_front();
		if (got.cube_value !== want.cube_value)
			flag_error($sformatf("cube_value %h, expected %h", got.cube_value, want.cube_value));
		if (got.cube_mask !== want.cube_mask)
			flag_error($sformatf("cube_mask %h, expected %h", got.cube_mask, want.cube_mask));
		if (got.essential !== want.essential)
			flag_error($sformatf("essential %b, expected %b (cube %h/%h)", got.essential,
				want.essential, want.cube_value, want.cube_mask));
		if (got.found !== want.found)
			flag_error($sformatf("found %b, expected %b", got.found, want.found));
		if (got.last !== want.last)
			flag_error($sformatf("last %b, expected %b (cube %h/%h)", got.last, want.last,
				want.cube_value, want.cube_mask));
	endtask

	function automatic in_item_t mk_load(int unsigned row, logic [1:0] kind);
		in_item_t it;
		it.action     = ActLoad;
		it.term_index = row[3:0];
		it.term_kind  = kind;
		return it;
	endfunction

	function automatic in_item_t mk_solve();
		in_item_t it;
		it.action     = ActSolve;
		it.term_index = 4'($urandom_range(0, 15));
		it.term_kind  = 2'($urandom_range(0, 3));
		return it;
	endfunction

	function automatic logic [1:0] rand_kind();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return KindOn;
		else if (r < 75)
			return KindDc;
		else if (r < 90)
			return KindOff;
		return KindUnused;
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive
		stim_t nxt;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_data  <= '0;
		end else begin
			if (drv_valid && cmd_if.ready) begin
				apply_cmd(drv_data);
				items_taken++;
			end
			if (!drv_valid || cmd_if.ready) begin
				if (stim_q.size() > 0 && $urandom_range(0, 99) >= tx_idle(stim_q[0].phase)) begin
					nxt = stim_q.pop_front();
					drv_valid <= 1'b1;
					drv_data  <= nxt.item;
					rx_phase  <= nxt.phase;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		if (!arst_n) begin
			rcv_ready <= 1'b0;
		end else begin
			if (res_if.valid && rcv_ready)
				check_prime(res_if.data);
			rcv_ready <= ($urandom_range(0, 99) >= rx_idle(rx_phase));
		end
	end

	always @(posedge clk or negedge arst_n) begin : watchdog
		if (!arst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet <= 0;
		end else if (quiet >= QuietMax) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		in_item_t    gen_q[$];
		stim_t       s;
		int unsigned r;
		int unsigned n;
		logic [1:0]  uk;

		// single minterm, single don't-care, empty table
		gen_q.push_back(mk_load(0, KindOn));
		gen_q.push_back(mk_solve());
		gen_q.push_back(mk_load(15, KindDc));
		gen_q.push_back(mk_solve());
		gen_q.push_back(mk_solve());
		// unused kind leaves the table empty
		gen_q.push_back(mk_load(9, KindUnused));
		gen_q.push_back(mk_solve());
		// set then clear a row
		gen_q.push_back(mk_load(6, KindOn));
		gen_q.push_back(mk_load(6, KindOff));
		gen_q.push_back(mk_solve());
		// don't-care overwritten by minterm, merged pair
		gen_q.push_back(mk_load(6, KindDc));
		gen_q.push_back(mk_load(6, KindOn));
		gen_q.push_back(mk_load(7, KindDc));
		gen_q.push_back(mk_solve());
		// star around a don't-care center
		gen_q.push_back(mk_load(1, KindOn));
		gen_q.push_back(mk_load(2, KindOn));
		gen_q.push_back(mk_load(4, KindOn));
		gen_q.push_back(mk_load(8, KindOn));
		gen_q.push_back(mk_load(0, KindDc));
		gen_q.push_back(mk_solve());

		n = NumRand;
		while (gen_q.size() < n) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				gen_q.push_back(in_item_t'(7'($urandom_range(0, 127))));
			end else if (r <= 3) begin
				// full sweep; sometimes one kind for every row
				uk = 2'($urandom_range(0, 2));
				if ($urandom_range(0, 3) == 0) begin
					for (int i = 0; i < 16; i++)
						gen_q.push_back(mk_load(i, uk));
				end else begin
					for (int i = 0; i < 16; i++)
						gen_q.push_back(mk_load(i, rand_kind()));
				end
				gen_q.push_back(mk_solve());
			end else begin
				repeat ($urandom_range(1, 8))
					gen_q.push_back(mk_load($urandom_range(0, 15), rand_kind()));
				gen_q.push_back(mk_solve());
			end
		end
		gen_q.push_back(mk_solve());

		foreach (gen_q[i]) begin
			s.item  = gen_q[i];
			s.phase = (i * 3) / gen_q.size();
			stim_q.push_back(s);
		end
		n_items = gen_q.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (items_taken < n_items)
			@(posedge clk);
		while (primes_due.size() > 0)
			@(posedge clk);
		repeat (DrainCyc) @(posedge clk);

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
